>>> rtl/tafs_pkg.sv
// Shared types and constants for the tilt accent F0 synthesis unit.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package tafs_pkg;

	// Operation codes carried in a request
	localparam logic OP_BASE   = 1'b0;
	localparam logic OP_ACCENT = 1'b1;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_STEP   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TRACK_LENGTH = 2'd1;
	localparam logic [15:0] FRAME_STEP_RST   = 16'd50;
	localparam logic [10:0] TRACK_LENGTH_RST = 11'd1024;

	// Datapath widths
	localparam int DIV_DVD_W = 48;
	localparam int DIV_DSR_W = 32;
	localparam int TERM_W    = 41;
	localparam int SUM_W     = 45;

	// log2(e) in Q30
	localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;

	typedef struct packed {
		logic               operation;
		logic [9:0]         frame_index;
		logic signed [31:0] base_value;
		logic [23:0]        start_time;
		logic signed [31:0] peak_level;
		logic signed [31:0] accent_amplitude;
		logic [15:0]        accent_duration;
		logic signed [15:0] tilt_shape;
	} tafs_req_t;

	typedef struct packed {
		logic [9:0]         out_frame;
		logic signed [31:0] f0_value;
		logic               last;
		logic               truncated;
	} tafs_res_t;

	// 2^(2^-(idx+1)) in Q30, one entry per fraction bit
	function automatic logic [30:0] pow2_frac(input logic [3:0] idx);
		logic [30:0] v;
		case (idx)
			4'd0:    v = 31'd1518500250;
			4'd1:    v = 31'd1276901417;
			4'd2:    v = 31'd1170923762;
			4'd3:    v = 31'd1121280439;
			4'd4:    v = 31'd1097253708;
			4'd5:    v = 31'd1085434104;
			4'd6:    v = 31'd1079572136;
			4'd7:    v = 31'd1076653033;
			4'd8:    v = 31'd1075196443;
			4'd9:    v = 31'd1074468888;
			4'd10:   v = 31'd1074105294;
			4'd11:   v = 31'd1073923544;
			4'd12:   v = 31'd1073832680;
			4'd13:   v = 31'd1073787251;
			4'd14:   v = 31'd1073764537;
			default: v = 31'd1073753181;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

>>> rtl/tafs_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on tafs_pkg for operand widths.
`default_nettype none

module tafs_div import tafs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_DVD_W-1:0] dividend,
	input  logic [DIV_DSR_W-1:0] divisor,
	output logic                 done,
	output logic [DIV_DVD_W-1:0] quotient,
	output logic [DIV_DSR_W-1:0] remainder
);

	localparam int CNT_W = $clog2(DIV_DVD_W);

	logic                 run_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIV_DVD_W-1:0] dvd_q;
	logic [DIV_DSR_W-1:0] dsr_q;
	logic [DIV_DSR_W-1:0] rem_q;
	logic [DIV_DSR_W:0]   rem_sh_w;
	logic                 fits_w;

	// shift in the next dividend bit and trial subtract
	assign rem_sh_w = {rem_q, dvd_q[DIV_DVD_W-1]};
	assign fits_w   = rem_sh_w >= {1'b0, dsr_q};

	// sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_DVD_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: quotient bits replace dividend bits from the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[DIV_DVD_W-2:0], fits_w};
			rem_q <= fits_w ? DIV_DSR_W'(rem_sh_w - {1'b0, dsr_q}) : DIV_DSR_W'(rem_sh_w);
		end
	end

	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

>>> rtl/tafs_term.sv
// Parabola term pipeline: min(2*mag*floor(x^2/2^16), 2^56) / 2^16.
// Three stages; depends on tafs_pkg for the term width.
`default_nettype none

module tafs_term import tafs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [31:0]       x,
	input  logic [31:0]       mag,
	output logic              valid,
	output logic [TERM_W-1:0] term
);

	logic              vld_s1, vld_s2, vld_s3;
	logic [47:0]       sq_s1;
	logic [31:0]       mag_s1;
	logic [55:0]       plo_s2, phi_s2;
	logic [TERM_W-1:0] term_s3;
	logic [63:0]       sq_full_w;
	logic [79:0]       prod_w;

	assign sq_full_w = 64'(x) * 64'(x);
	assign prod_w    = {phi_s2, 24'b0} + 80'(plo_s2);

	// advance the valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// square, split product, saturate
	always_ff @(posedge clk) begin
		sq_s1   <= sq_full_w[63:16];
		mag_s1  <= mag;
		plo_s2  <= 56'(mag_s1) * 56'(sq_s1[23:0]);
		phi_s2  <= 56'(mag_s1) * 56'(sq_s1[47:24]);
		term_s3 <= (prod_w > 80'h80_0000_0000_0000) ? {1'b1, 40'b0} : prod_w[55:15];
	end

	assign valid = vld_s3;
	assign term  = term_s3;

endmodule

`default_nettype wire

>>> rtl/tafs_exp.sv
// Fixed-point exp of a Q16.16 value, saturating, by base-2 decomposition.
// One table product per cycle; depends on tafs_pkg for the table and widths.
`default_nettype none

module tafs_exp import tafs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [SUM_W-1:0] x,
	output logic                    done,
	output logic [31:0]             value
);

	localparam logic [1:0] EX_IDLE = 2'd0;
	localparam logic [1:0] EX_MUL  = 2'd1;
	localparam logic [1:0] EX_ITER = 2'd2;
	localparam logic [1:0] EX_FIN  = 2'd3;

	localparam logic signed [SUM_W-1:0] X_LIM = SUM_W'(1048576);

	logic [1:0]         st_q;
	logic [3:0]         bit_q;
	logic               done_q;
	logic signed [21:0] xc_q;
	logic signed [53:0] prod_q;
	logic [31:0]        m_q;
	logic [31:0]        val_q;
	logic signed [21:0] xc_w;
	logic signed [23:0] y_w;
	logic signed [7:0]  n_w;
	logic [15:0]        f_w;
	logic [31:0]        res_w;
	logic [63:0]        mp_w;

	// clamp to +-16.0
	always_comb begin
		if (x > X_LIM) begin
			xc_w = 22'sd1048576;
		end else if (x < -X_LIM) begin
			xc_w = -22'sd1048576;
		end else begin
			xc_w = x[21:0];
		end
	end

	assign y_w  = 24'(prod_q >>> 30);
	assign n_w  = y_w[23:16];
	assign f_w  = y_w[15:0];
	assign mp_w = 64'(m_q) * 64'(pow2_frac(bit_q));

	// scale by 2^(n-14) with round half up
	always_comb begin
		logic signed [7:0] sh;
		logic [5:0]        k;
		logic [39:0]       r;
		sh    = n_w - 8'sd14;
		k     = 6'(-sh);
		r     = 40'(m_q);
		res_w = 32'h7FFF_FFFF;
		if (sh <= 8'sd0) begin
			if (sh != 8'sd0) begin
				r = (40'(m_q) + (40'd1 << (k - 6'd1))) >> k;
			end
			res_w = (r > 40'h7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
		end
	end

	// sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= EX_IDLE;
			bit_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				EX_IDLE: begin
					if (start) begin
						st_q <= EX_MUL;
					end
				end
				EX_MUL: begin
					bit_q <= '0;
					st_q  <= EX_ITER;
				end
				EX_ITER: begin
					bit_q <= bit_q + 1'b1;
					if (bit_q == 4'd15) begin
						st_q <= EX_FIN;
					end
				end
				EX_FIN: begin
					done_q <= 1'b1;
					st_q   <= EX_IDLE;
				end
				default: st_q <= EX_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (st_q == EX_IDLE && start) begin
			xc_q <= xc_w;
		end
		if (st_q == EX_MUL) begin
			prod_q <= 54'(xc_q) * $signed(54'(LOG2E_Q30));
			m_q    <= 32'h4000_0000;
		end
		if (st_q == EX_ITER && f_w[4'd15 - bit_q]) begin
			m_q <= 32'(mp_w >> 30);
		end
		if (st_q == EX_FIN) begin
			val_q <= res_w;
		end
	end

	assign done  = done_q;
	assign value = val_q;

endmodule

`default_nettype wire

>>> rtl/tilt_accent_f0_synthesis_unit.sv
// Top level of the tilt accent F0 synthesis unit: frame track memory and sequencer.
// Depends on tafs_pkg, tafs_div, tafs_term and tafs_exp.
//
// A base write (operation 0) stores one log-F0 frame and gives no result;
// busy stays low. An accent event (operation 1) raises busy for its whole run: a setup
// dominated by three passes of the shared divider (start frame and the rise and fall
// ratio steps), then for each frame a registered track read, the three-stage parabola
// pipeline, and the exp unit that walks sixteen table products one multiply per cycle.
// Each updated frame is written back and shown on result for one cycle with result_valid;
// the receiver cannot stall, so it must take every result as it appears. Frames never
// written read back undefined.
`default_nettype none

module tilt_accent_f0_synthesis_unit import tafs_pkg::*; #(
	parameter int TRACK_FRAMES     = 1024,
	parameter int MAX_EVENT_FRAMES = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  tafs_req_t             request,
	output tafs_res_t             result,
	output logic                  result_valid,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW    = $clog2(TRACK_FRAMES);
	localparam int CNT_W = $clog2(MAX_EVENT_FRAMES + 1);
	localparam int POS_W = 44;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_PREP   = 4'd1;
	localparam logic [3:0] ST_TIMES  = 4'd2;
	localparam logic [3:0] ST_DIV_N0 = 4'd3;
	localparam logic [3:0] ST_DIV_R  = 4'd4;
	localparam logic [3:0] ST_DIV_F  = 4'd5;
	localparam logic [3:0] ST_POS    = 4'd6;
	localparam logic [3:0] ST_CHECK  = 4'd7;
	localparam logic [3:0] ST_FRAME  = 4'd8;
	localparam logic [3:0] ST_RD     = 4'd9;
	localparam logic [3:0] ST_TERM   = 4'd10;
	localparam logic [3:0] ST_SUM    = 4'd11;
	localparam logic [3:0] ST_EXP    = 4'd12;

	localparam logic [1:0] PH_R1 = 2'd0;
	localparam logic [1:0] PH_R2 = 2'd1;
	localparam logic [1:0] PH_F1 = 2'd2;
	localparam logic [1:0] PH_F2 = 2'd3;

	localparam logic [32:0] Q_SAT = 33'h1_0000_0000;

	// control
	logic [3:0]  state_q;
	logic [15:0] step_q;
	logic [10:0] len_q;
	logic        result_valid_q;
	tafs_res_t   result_q;

	// event datapath
	tafs_req_t          req_q;
	logic signed [32:0] arise_q, afall_q;
	logic [31:0]        dr_q, df_q;
	logic [POS_W-1:0]   t1_q, t2_q, t3_q, t4_q;
	logic [24:0]        n0_q;
	logic [32:0]        q0r_q, q0f_q, qr_q, qf_q;
	logic [31:0]        r0r_q, r0f_q, remr_q, remf_q;
	logic [10:0]        num_q;
	logic [POS_W-1:0]   pos_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               trunc_q;
	logic [1:0]         phase_q;
	logic [TERM_W-1:0]  term_q;
	logic [31:0]        rd_q;

	logic [31:0] track_mem [TRACK_FRAMES];

	// combinational
	logic                  accept_w;
	logic [15:0]           step_w;
	logic [10:0]           len_w;
	logic signed [15:0]    tc_w;
	logic [15:0]           tp_w, tm_w;
	logic signed [48:0]    arise_p_w, afall_p_w;
	logic [POS_W-1:0]      ss_w, t2_w, step16_w, mstep_w;
	logic                  div_start_w, div_done_w;
	logic [DIV_DVD_W-1:0]  div_dvd_w, div_quot_w;
	logic [DIV_DSR_W-1:0]  div_dsr_w, div_rem_w;
	logic [1:0]            phase_w;
	logic                  rising_w;
	logic [32:0]           qr_next_w, qf_next_w;
	logic [31:0]           remr_next_w, remf_next_w;
	logic [31:0]           ratio_w, x_w, mag_w;
	logic signed [32:0]    a_w;
	logic                  term_valid_w;
	logic [TERM_W-1:0]     term_w;
	logic signed [SUM_W-1:0] sum_w;
	logic                  exp_done_w;
	logic [31:0]           exp_val_w;
	logic                  next_ok_w;
	logic                  mem_we_w;
	logic [AW-1:0]         mem_waddr_w;
	logic [31:0]           mem_wdata_w;
	logic [26:0]           pos_mult_w;

	// saturate a ratio quotient at 2^32
	function automatic logic [32:0] sat_q(input logic [DIV_DVD_W-1:0] q);
		return (q > DIV_DVD_W'(Q_SAT)) ? Q_SAT : q[32:0];
	endfunction

	// one |2^16 - r|
	function automatic logic [31:0] one_minus(input logic [31:0] r);
		return (r > 32'd65536) ? (r - 32'd65536) : (32'd65536 - r);
	endfunction

	assign accept_w  = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// effective registers
	assign step_w = (step_q == '0) ? 16'd1 : step_q;
	assign len_w  = (32'(len_q) > 32'(TRACK_FRAMES)) ? 11'(TRACK_FRAMES) : len_q;

	// split amplitude and duration by the clamped tilt
	always_comb begin
		if (req_q.tilt_shape > 16'sd16384) begin
			tc_w = 16'sd16384;
		end else if (req_q.tilt_shape < -16'sd16384) begin
			tc_w = -16'sd16384;
		end else begin
			tc_w = req_q.tilt_shape;
		end
	end
	assign tp_w      = 16'(17'sd16384 + 17'(tc_w));
	assign tm_w      = 16'(17'sd16384 - 17'(tc_w));
	assign arise_p_w = 49'($signed(req_q.accent_amplitude)) * 49'($signed({1'b0, tp_w}));
	assign afall_p_w = 49'($signed(req_q.accent_amplitude)) * 49'($signed({1'b0, tm_w}));

	// phase limits, all scaled by 2^16
	assign ss_w     = POS_W'(req_q.start_time) << 16;
	assign t2_w     = ss_w + (POS_W'(dr_q) << 1);
	assign step16_w = POS_W'(step_w) << 16;
	assign mstep_w  = POS_W'(32'(step_w) * 32'(MAX_EVENT_FRAMES)) << 16;
	assign pos_mult_w = 27'(n0_q[10:0]) * 27'(step_w);

	// shared divider: start frame, then rise and fall ratio steps
	assign div_start_w = (state_q == ST_TIMES) ||
		((state_q == ST_DIV_N0 || state_q == ST_DIV_R) && div_done_w);
	assign div_dvd_w = (state_q == ST_TIMES) ? DIV_DVD_W'(req_q.start_time)
		: {1'b0, step_w, 31'b0};
	always_comb begin
		if (state_q == ST_TIMES) begin
			div_dsr_w = DIV_DSR_W'(step_w);
		end else if (state_q == ST_DIV_N0) begin
			div_dsr_w = dr_q;
		end else begin
			div_dsr_w = df_q;
		end
	end

	tafs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start_w),
		.dividend  (div_dvd_w),
		.divisor   (div_dsr_w),
		.done      (div_done_w),
		.quotient  (div_quot_w),
		.remainder (div_rem_w)
	);

	// phase of the current frame
	always_comb begin
		if (pos_q < t1_q) begin
			phase_w = PH_R1;
		end else if (pos_q < t2_q) begin
			phase_w = PH_R2;
		end else if (pos_q < t3_q) begin
			phase_w = PH_F1;
		end else begin
			phase_w = PH_F2;
		end
	end

	// advance the ratio quotients by one step, remainder carried exactly
	always_comb begin
		logic [32:0] rs_r, rs_f;
		logic [33:0] qs_r, qs_f;
		logic        wr, wf;
		rs_r = {1'b0, remr_q} + {1'b0, r0r_q};
		rs_f = {1'b0, remf_q} + {1'b0, r0f_q};
		wr   = rs_r >= {1'b0, dr_q};
		wf   = rs_f >= {1'b0, df_q};
		remr_next_w = wr ? 32'(rs_r - {1'b0, dr_q}) : rs_r[31:0];
		remf_next_w = wf ? 32'(rs_f - {1'b0, df_q}) : rs_f[31:0];
		qs_r = {1'b0, qr_q} + {1'b0, q0r_q} + 34'(wr);
		qs_f = {1'b0, qf_q} + {1'b0, q0f_q} + 34'(wf);
		qr_next_w = (qs_r >= 34'(Q_SAT)) ? Q_SAT : qs_r[32:0];
		qf_next_w = (qs_f >= 34'(Q_SAT)) ? Q_SAT : qs_f[32:0];
	end

	// term operands
	assign rising_w = (phase_q == PH_R1 || phase_q == PH_R2);
	assign a_w      = rising_w ? arise_q : afall_q;
	always_comb begin
		logic [32:0] q;
		q = rising_w ? qr_q : qf_q;
		ratio_w = q[32] ? 32'hFFFF_FFFF : q[31:0];
	end
	assign x_w   = (phase_q == PH_R1 || phase_q == PH_F1) ? ratio_w : one_minus(ratio_w);
	assign mag_w = a_w[32] ? 32'(-a_w) : 32'(a_w);

	tafs_term u_term (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_RD),
		.x      (x_w),
		.mag    (mag_w),
		.valid  (term_valid_w),
		.term   (term_w)
	);

	// stored value plus piece
	always_comb begin
		logic signed [SUM_W-1:0] p, tv, piece;
		logic                    plus;
		plus  = (phase_q == PH_R1 || phase_q == PH_F2);
		p     = $signed(SUM_W'(term_q));
		tv    = a_w[32] ? -p : p;
		piece = SUM_W'($signed(req_q.peak_level));
		if (plus) begin
			piece = piece - SUM_W'(a_w) + tv;
		end else begin
			piece = piece - tv;
		end
		sum_w = SUM_W'($signed(rd_q)) + piece;
	end

	tafs_exp u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_SUM),
		.x      (sum_w),
		.done   (exp_done_w),
		.value  (exp_val_w)
	);

	// does a further frame follow this one
	assign next_ok_w = (12'(num_q) + 12'd1 < 12'(len_w)) && (pos_q + step16_w < t4_q) &&
		(CNT_W'(cnt_q + 1'b1) != CNT_W'(MAX_EVENT_FRAMES));

	// track write port: base writes when idle, updated frames when emitting
	assign mem_we_w = (accept_w && request.operation == OP_BASE &&
		32'(request.frame_index) < 32'(TRACK_FRAMES)) || (state_q == ST_EXP && exp_done_w);
	assign mem_waddr_w = (state_q == ST_EXP) ? AW'(num_q) : AW'(request.frame_index);
	assign mem_wdata_w = (state_q == ST_EXP) ? exp_val_w : request.base_value;

	// frame track memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we_w) begin
			track_mem[mem_waddr_w] <= mem_wdata_w;
		end
		if (state_q == ST_FRAME) begin
			rd_q <= track_mem[AW'(num_q)];
		end
	end

	// sequencer, configuration and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			step_q         <= FRAME_STEP_RST;
			len_q          <= TRACK_LENGTH_RST;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FRAME_STEP:   step_q <= cfg_data;
					CFG_TRACK_LENGTH: len_q  <= cfg_data[10:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (accept_w && request.operation == OP_ACCENT) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP:  state_q <= ST_TIMES;
				ST_TIMES: state_q <= ST_DIV_N0;
				ST_DIV_N0: begin
					if (div_done_w) begin
						state_q <= ST_DIV_R;
					end
				end
				ST_DIV_R: begin
					if (div_done_w) begin
						state_q <= ST_DIV_F;
					end
				end
				ST_DIV_F: begin
					if (div_done_w) begin
						state_q <= ST_POS;
					end
				end
				ST_POS: begin
					state_q <= (n0_q >= 25'(len_w)) ? ST_IDLE : ST_CHECK;
				end
				ST_CHECK: begin
					state_q <= (pos_q >= t4_q) ? ST_IDLE : ST_FRAME;
				end
				ST_FRAME: state_q <= ST_RD;
				ST_RD:    state_q <= ST_TERM;
				ST_TERM: begin
					if (term_valid_w) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: state_q <= ST_EXP;
				ST_EXP: begin
					if (exp_done_w) begin
						result_valid_q <= 1'b1;
						state_q        <= next_ok_w ? ST_FRAME : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// event datapath
	always_ff @(posedge clk) begin
		if (accept_w && request.operation == OP_ACCENT) begin
			req_q <= request;
		end
		if (state_q == ST_PREP) begin
			arise_q <= 33'(arise_p_w >>> 15);
			afall_q <= 33'(afall_p_w >>> 15);
			dr_q    <= 32'(req_q.accent_duration) * 32'(tp_w);
			df_q    <= 32'(req_q.accent_duration) * 32'(tm_w);
		end
		if (state_q == ST_TIMES) begin
			t1_q <= ss_w + POS_W'(dr_q);
			t2_q <= t2_w;
			t3_q <= t2_w + POS_W'(df_q);
			t4_q <= t2_w + (POS_W'(df_q) << 1);
		end
		if (div_done_w) begin
			if (state_q == ST_DIV_N0) begin
				n0_q <= div_quot_w[24:0] + 25'(div_rem_w != '0);
			end
			if (state_q == ST_DIV_R) begin
				q0r_q <= (dr_q == '0) ? Q_SAT : sat_q(div_quot_w);
				r0r_q <= (dr_q == '0) ? 32'd0 : div_rem_w;
			end
			if (state_q == ST_DIV_F) begin
				q0f_q <= (df_q == '0) ? Q_SAT : sat_q(div_quot_w);
				r0f_q <= (df_q == '0) ? 32'd0 : div_rem_w;
			end
		end
		if (state_q == ST_POS) begin
			num_q  <= n0_q[10:0];
			pos_q  <= POS_W'({pos_mult_w, 16'b0});
			qr_q   <= '0;
			qf_q   <= '0;
			remr_q <= '0;
			remf_q <= '0;
			cnt_q  <= '0;
		end
		if (state_q == ST_CHECK) begin
			trunc_q <= (12'(num_q) + 12'(MAX_EVENT_FRAMES) < 12'(len_w)) &&
				(pos_q + mstep_w < t4_q);
		end
		if (state_q == ST_FRAME) begin
			phase_q <= phase_w;
			if (phase_w == PH_R1 || phase_w == PH_R2) begin
				qr_q   <= qr_next_w;
				remr_q <= remr_next_w;
			end else begin
				qf_q   <= qf_next_w;
				remf_q <= remf_next_w;
			end
		end
		if (state_q == ST_TERM && term_valid_w) begin
			term_q <= term_w;
		end
		if (state_q == ST_EXP && exp_done_w) begin
			result_q.out_frame <= num_q[9:0];
			result_q.f0_value  <= exp_val_w;
			result_q.last      <= !next_ok_w;
			result_q.truncated <= trunc_q;
			num_q <= num_q + 1'b1;
			pos_q <= pos_q + step16_w;
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

`default_nettype wire

>>> rtl/tafs_checker.sv
// Port-level checks for the tilt accent F0 synthesis unit, bound to the top level.
// Depends on tafs_pkg and tilt_accent_f0_synthesis_unit.
`default_nettype none

module tafs_checker import tafs_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input tafs_req_t request,
	input tafs_res_t result,
	input logic      result_valid
);

	// a base write request completes at once
	a_base_quick: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && request.operation == OP_BASE |=> !busy)
		else $error("base write left the unit busy");

	// an accent request always occupies the unit
	a_accent_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && request.operation == OP_ACCENT |=> busy)
		else $error("accent request did not raise busy");

	// more results follow only while the unit is still working
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |-> busy)
		else $error("non-final result while idle");

	// results are spaced apart
	a_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("back-to-back results");

endmodule

bind tilt_accent_f0_synthesis_unit tafs_checker u_tafs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.request      (request),
	.result       (result),
	.result_valid (result_valid)
);

`default_nettype wire
